// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_IMPLY(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/rmsg_pkg.sv =====
// Package for the voice gate: widths, frame constants, register codes and shared types.
package rmsg_pkg;

   localparam int FRAME_SAMPLES  = 1600;
   localparam int FRAME_MAX_FILL = FRAME_SAMPLES + FRAME_SAMPLES / 2 - 1;
   localparam int FRAME_HALF     = FRAME_SAMPLES / 2;

   localparam int SAMPLE_W = 16;
   localparam int AFTER_W  = 16;
   localparam int SQ_W     = 32;
   localparam int SUM_W    = 44;
   localparam int FILL_W   = $clog2(FRAME_MAX_FILL + 1);
   localparam int POS_W    = 24;
   localparam int EST_W    = 32;
   localparam int RMS_W    = 16;
   localparam int LEVEL_W  = 15;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 15;

   localparam logic [CSR_IDX_W-1:0] CSR_GATE_MIN_RMS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VOICE_GAIN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR_CAP    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR_START  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FALL_SHIFT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RISE_SHIFT   = 3'd5;

   localparam logic [14:0] GATE_MIN_RMS_RST = 15'd49;
   localparam logic [7:0]  VOICE_GAIN_RST   = 8'd40;
   localparam logic [14:0] FLOOR_CAP_RST    = 15'd328;
   localparam logic [14:0] FLOOR_START_RST  = 15'd164;
   localparam logic [3:0]  FALL_SHIFT_RST   = 4'd1;
   localparam logic [4:0]  RISE_SHIFT_RST   = 5'd11;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [14:0] gate_min_rms;
      logic [7:0]  voice_gain;
      logic [14:0] floor_cap;
      logic [14:0] floor_start;
      logic [3:0]  fall_shift;
      logic [4:0]  rise_shift;
   } cfg_type;

   // One job for the back end: a closed frame or a session start.
   typedef struct packed {
      logic              start;
      logic [SUM_W-1:0]  sum;
      logic [FILL_W-1:0] fill;
      logic [POS_W-1:0]  pos;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// ===== rtl/rmsg_front.sv =====
// Front end: accepts samples, accumulates frame energy, emits frame-close and start jobs.
module rmsg_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   input  logic                            req_command,
   input  logic signed [rmsg_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [rmsg_pkg::AFTER_W-1:0]    req_samples_after,
   input  logic                            queue_full,
   output logic                            job_push,
   output rmsg_pkg::job_type               job
);
   import rmsg_pkg::*;

   logic [SUM_W-1:0]  energy_ff, energy_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [POS_W-1:0]  window_ff, window_in;

   logic                     accept;
   logic signed [SQ_W-1:0]   square;
   logic [SUM_W-1:0]         sum_next;
   logic [FILL_W-1:0]        fill_next;
   logic [POS_W-1:0]         window_next;
   logic                     close;

   always_comb begin
      accept      = req_push && !queue_full;
      square      = SQ_W'(req_sample) * SQ_W'(req_sample);
      sum_next    = energy_ff + {{(SUM_W-SQ_W){1'b0}}, $unsigned(square)};
      fill_next   = fill_ff + FILL_W'(1);
      window_next = (window_ff == {POS_W{1'b1}}) ? window_ff : window_ff + POS_W'(1);
      close = (req_samples_after == '0) ||
              (fill_next >= FILL_W'(FRAME_MAX_FILL)) ||
              ((fill_next == FILL_W'(FRAME_SAMPLES)) &&
               (req_samples_after >= AFTER_W'(FRAME_HALF)));

      energy_in = energy_ff;
      fill_in   = fill_ff;
      window_in = window_ff;
      if (accept) begin
         if (req_command) begin
            energy_in = '0;
            fill_in   = '0;
            window_in = '0;
         end else begin
            window_in = window_next;
            energy_in = close ? '0 : sum_next;
            fill_in   = close ? '0 : fill_next;
         end
      end

      job_push  = accept && (req_command || close);
      job.start = req_command;
      job.sum   = sum_next;
      job.fill  = fill_next;
      job.pos   = window_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         energy_ff <= '0;
         fill_ff   <= '0;
         window_ff <= '0;
      end else begin
         energy_ff <= energy_in;
         fill_ff   <= fill_in;
         window_ff <= window_in;
      end
   end

endmodule

// ===== rtl/rmsg_queue.sv =====
// Short job queue between the front end and the back end.
module rmsg_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rmsg_pkg::job_type push_job,
   input  logic              pop,
   output rmsg_pkg::job_type pop_job,
   output rmsg_pkg::qstat_type status
);
   import rmsg_pkg::*;

   job_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                do_push, do_pop;

   always_comb begin
      status.full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
      status.empty = (count_ff == '0);
      do_push = push && !status.full;
      do_pop  = pop && !status.empty;
      wr_in    = do_push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in    = do_pop ? rd_ff + QPTR_W'(1) : rd_ff;
      count_in = count_ff + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
      pop_job  = slot_ff[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/rmsg_back.sv =====
// Back end: divide, integer square root, noise floor update, voice decision, result register.
module rmsg_back (
   input  logic                          clock,
   input  logic                          reset,
   input  rmsg_pkg::cfg_type             cfg,
   input  rmsg_pkg::job_type             job,
   input  rmsg_pkg::qstat_type           qstat,
   output logic                          job_pop,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [rmsg_pkg::RMS_W-1:0]    rsp_frame_rms,
   output logic                          rsp_frame_voiced,
   output logic [rmsg_pkg::LEVEL_W-1:0]  rsp_floor_level,
   output logic [rmsg_pkg::POS_W-1:0]    rsp_voiced_end
);
   import rmsg_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_SQRT = 3'd2;
   localparam logic [2:0] ST_UPD  = 3'd3;
   localparam logic [2:0] ST_THR  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   localparam int DIV_CNT_W  = $clog2(SUM_W);
   localparam int SQRT_STEPS = EST_W / 2;
   localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);

   logic [2:0]            state_ff, state_in;
   logic [FILL_W:0]       rem_ff, rem_in;
   logic [SUM_W-1:0]      quo_ff, quo_in;
   logic [FILL_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0]  dcnt_ff, dcnt_in;
   logic [EST_W-1:0]      sv_ff, sv_in;
   logic [EST_W-1:0]      res_ff, res_in;
   logic [EST_W-1:0]      bit_ff, bit_in;
   logic [SQRT_CNT_W-1:0] scnt_ff, scnt_in;
   logic [RMS_W-1:0]      rms_ff, rms_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [EST_W-1:0]      est_ff, est_in;
   logic [POS_W-1:0]      lastv_ff, lastv_in;
   logic                  voiced_ff, voiced_in;
   logic                  out_valid_ff, out_valid_in;
   logic [RMS_W-1:0]      out_rms_ff, out_rms_in;
   logic                  out_voiced_ff, out_voiced_in;
   logic [LEVEL_W-1:0]    out_level_ff, out_level_in;
   logic [POS_W-1:0]      out_end_ff, out_end_in;

   logic [FILL_W:0]       rem_shift;
   logic                  rem_ge;
   logic [EST_W-1:0]      trial;
   logic [EST_W-1:0]      r31;
   logic [EST_W-1:0]      step_dn;
   logic [EST_W:0]        est_up;
   logic [EST_W:0]        est_new;
   logic [EST_W:0]        cap;
   logic [EST_W+7:0]      thr;
   logic [EST_W+7:0]      rms_scaled;
   logic                  out_free;

   always_comb begin
      rem_shift = {rem_ff[FILL_W-1:0], quo_ff[SUM_W-1]};
      rem_ge    = (rem_shift >= {1'b0, dvs_ff});
      trial     = res_ff + bit_ff;
      r31       = {rms_ff, {(EST_W-RMS_W){1'b0}}};
      step_dn   = est_ff - ((est_ff - r31) >> cfg.fall_shift);
      est_up    = {1'b0, est_ff} + {1'b0, (r31 - est_ff) >> cfg.rise_shift};
      est_new   = (r31 < est_ff) ? {1'b0, step_dn} : est_up;
      cap       = {2'b0, cfg.floor_cap, {(EST_W-LEVEL_W-1){1'b0}}};
      thr       = (EST_W+8)'(cfg.voice_gain) * (EST_W+8)'(est_ff);
      rms_scaled = {{(EST_W+8-RMS_W-20){1'b0}}, rms_ff, 20'b0};
      out_free  = !out_valid_ff || rsp_pop;

      state_in  = state_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      dcnt_in   = dcnt_ff;
      sv_in     = sv_ff;
      res_in    = res_ff;
      bit_in    = bit_ff;
      scnt_in   = scnt_ff;
      rms_in    = rms_ff;
      pos_in    = pos_ff;
      est_in    = est_ff;
      lastv_in  = lastv_ff;
      voiced_in = voiced_ff;
      job_pop   = 1'b0;

      out_valid_in  = out_valid_ff && !rsp_pop;
      out_rms_in    = out_rms_ff;
      out_voiced_in = out_voiced_ff;
      out_level_in  = out_level_ff;
      out_end_in    = out_end_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty) begin
               job_pop = 1'b1;
               if (job.start) begin
                  est_in   = {1'b0, cfg.floor_start, {(EST_W-LEVEL_W-1){1'b0}}};
                  lastv_in = '0;
               end else begin
                  rem_in   = '0;
                  quo_in   = job.sum;
                  dvs_in   = job.fill;
                  pos_in   = job.pos;
                  dcnt_in  = DIV_CNT_W'(SUM_W - 1);
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            // One quotient bit per cycle, restoring.
            rem_in  = rem_ge ? rem_shift - {1'b0, dvs_ff} : rem_shift;
            quo_in  = {quo_ff[SUM_W-2:0], rem_ge};
            dcnt_in = dcnt_ff - DIV_CNT_W'(1);
            if (dcnt_ff == '0) begin
               sv_in    = quo_in[EST_W-1:0];
               res_in   = '0;
               bit_in   = {2'b01, {(EST_W-2){1'b0}}};
               scnt_in  = SQRT_CNT_W'(SQRT_STEPS - 1);
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            // One root bit per cycle.
            if (sv_ff >= trial) begin
               sv_in  = sv_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            scnt_in = scnt_ff - SQRT_CNT_W'(1);
            if (scnt_ff == '0) begin
               rms_in   = res_in[RMS_W-1:0];
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            est_in   = (est_new > cap) ? cap[EST_W-1:0] : est_new[EST_W-1:0];
            state_in = ST_THR;
         end
         ST_THR: begin
            voiced_in = (rms_scaled >= thr) &&
                        (rms_ff >= {1'b0, cfg.gate_min_rms});
            if (voiced_in) begin
               lastv_in = pos_ff;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Hold until the result register frees up.
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_rms_in    = rms_ff;
               out_voiced_in = voiced_ff;
               out_level_in  = est_ff[EST_W-2:EST_W-LEVEL_W-1];
               out_end_in    = lastv_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_empty        = !out_valid_ff;
      rsp_frame_rms    = out_rms_ff;
      rsp_frame_voiced = out_voiced_ff;
      rsp_floor_level  = out_level_ff;
      rsp_voiced_end   = out_end_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         est_ff       <= {1'b0, FLOOR_START_RST, {(EST_W-LEVEL_W-1){1'b0}}};
         lastv_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         est_ff       <= est_in;
         lastv_ff     <= lastv_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      dvs_ff        <= dvs_in;
      dcnt_ff       <= dcnt_in;
      sv_ff         <= sv_in;
      res_ff        <= res_in;
      bit_ff        <= bit_in;
      scnt_ff       <= scnt_in;
      rms_ff        <= rms_in;
      pos_ff        <= pos_in;
      voiced_ff     <= voiced_in;
      out_rms_ff    <= out_rms_in;
      out_voiced_ff <= out_voiced_in;
      out_level_ff  <= out_level_in;
      out_end_ff    <= out_end_in;
   end

endmodule

// ===== rtl/rms_energy_voice_gate_top.sv =====
// Top level of the energy voice gate: register file and front/queue/back wiring.
//
// Input queue side: drive req_command, req_sample and req_samples_after and raise
// req_push; the transaction is taken on a clock edge where req_full is low. Samples
// are taken one per cycle while req_full is low; the front end squares and sums each.
// A frame close or a start command becomes a job in a four-entry queue; req_full
// rises only while that queue is full.
// Result queue side: while rsp_empty is low a frame result is on the rsp_ ports,
// taken with rsp_pop. A stalled result holds; the back end then waits on it while
// the job queue keeps absorbing input until it fills.
// From the closing sample to its result: the job enters the queue on the accepting
// edge; the back end then pops it, runs the divider (one quotient bit a cycle) and the
// square root (one bit a cycle), then updates the floor, applies the threshold and
// loads the output register. The back end takes one frame at a time and pops no new
// job until that result is loaded; a start job is handled in the idle state itself.
// CSR port: csr_ready is always high; write only while the block is idle.
// Reset (synchronous): registers return to their defaults, the noise floor is
// loaded from the default start level, and both queues come up empty.
module rms_energy_voice_gate_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic                                   req_command,
   input  logic signed [rmsg_pkg::SAMPLE_W-1:0]   req_sample,
   input  logic [rmsg_pkg::AFTER_W-1:0]           req_samples_after,
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output logic [rmsg_pkg::RMS_W-1:0]             rsp_frame_rms,
   output logic                                   rsp_frame_voiced,
   output logic [rmsg_pkg::LEVEL_W-1:0]           rsp_floor_level,
   output logic [rmsg_pkg::POS_W-1:0]             rsp_voiced_end,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [rmsg_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [rmsg_pkg::CSR_DATA_W-1:0]        csr_data
);
   import rmsg_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   job_type   push_job, pop_job;
   logic      job_push, job_pop;
   qstat_type qstat;

   always_comb begin
      csr_ready = 1'b1;
      cfg_in    = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_GATE_MIN_RMS: cfg_in.gate_min_rms = csr_data;
            CSR_VOICE_GAIN:   cfg_in.voice_gain   = csr_data[7:0];
            CSR_FLOOR_CAP:    cfg_in.floor_cap    = csr_data;
            CSR_FLOOR_START:  cfg_in.floor_start  = csr_data;
            CSR_FALL_SHIFT:   cfg_in.fall_shift   = csr_data[3:0];
            CSR_RISE_SHIFT:   cfg_in.rise_shift   = csr_data[4:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gate_min_rms <= GATE_MIN_RMS_RST;
         cfg_ff.voice_gain   <= VOICE_GAIN_RST;
         cfg_ff.floor_cap    <= FLOOR_CAP_RST;
         cfg_ff.floor_start  <= FLOOR_START_RST;
         cfg_ff.fall_shift   <= FALL_SHIFT_RST;
         cfg_ff.rise_shift   <= RISE_SHIFT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_full = qstat.full;

   rmsg_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_command       (req_command),
      .req_sample        (req_sample),
      .req_samples_after (req_samples_after),
      .queue_full        (qstat.full),
      .job_push          (job_push),
      .job               (push_job)
   );

   rmsg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .pop      (job_pop),
      .pop_job  (pop_job),
      .status   (qstat)
   );

   rmsg_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .job              (pop_job),
      .qstat            (qstat),
      .job_pop          (job_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_frame_rms    (rsp_frame_rms),
      .rsp_frame_voiced (rsp_frame_voiced),
      .rsp_floor_level  (rsp_floor_level),
      .rsp_voiced_end   (rsp_voiced_end)
   );

endmodule

// ===== rtl/rmsg_checker.sv =====
// Port-level checker for the voice gate, bound to the top level.
`include "assert_macros.svh"

module rmsg_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_full,
   input logic                                 rsp_empty,
   input logic                                 rsp_pop,
   input logic [rmsg_pkg::RMS_W-1:0]           rsp_frame_rms,
   input logic                                 rsp_frame_voiced,
   input logic [rmsg_pkg::POS_W-1:0]           rsp_voiced_end
);

   // Result queue comes out of reset empty.
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, rsp_empty)

   // Job queue comes out of reset with room.
   `ASSERT_NEXT(a_reset_not_full, clock, 1'b0, reset, !req_full)

   // RMS of Q15 samples never exceeds full scale.
   `ASSERT_IMPLY(a_rms_range, clock, reset, !rsp_empty, rsp_frame_rms <= 16'd32768)

   // A voiced frame ends after at least one sample of the window.
   `ASSERT_IMPLY(a_voiced_end, clock, reset, !rsp_empty && rsp_frame_voiced, rsp_voiced_end != '0)

   // A waiting result holds until it is popped.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_frame_rms) && $stable(rsp_voiced_end))

endmodule

bind rms_energy_voice_gate_top rmsg_checker u_rmsg_checker (.*);

// ===== sim/rms_energy_voice_gate_top_tb.sv =====
// Self-checking bench for the energy voice gate: frame results scored against an in-bench model.
`timescale 1ns / 100ps

module rms_energy_voice_gate_top_tb;
   import rmsg_pkg::*;

   localparam int RESET_CYCLES   = 11;
   localparam int SETTLE_CYCLES  = 150;
   localparam int HOLD_CYCLES    = 1500;
   localparam int WATCHDOG_LIMIT = 10000;
   localparam int MAX_REPORTS    = 40;
   localparam int LOUD           = 32768;

   typedef enum logic {CMD_SAMPLE = 1'b0, CMD_START = 1'b1} gate_cmd_type;

   typedef struct {
      gate_cmd_type        cmd;
      logic [SAMPLE_W-1:0] sample;
      logic [AFTER_W-1:0]  remaining;
   } audio_item_type;

   typedef struct {
      logic [RMS_W-1:0]   rms;
      logic               voiced;
      logic [LEVEL_W-1:0] level;
      logic [POS_W-1:0]   voiced_end;
   } frame_result_type;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_push = 1'b0;
   logic                       req_full;
   logic                       req_command = 1'b0;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic [AFTER_W-1:0]         req_samples_after = '0;
   logic                       rsp_empty;
   logic                       rsp_pop = 1'b0;
   logic [RMS_W-1:0]           rsp_frame_rms;
   logic                       rsp_frame_voiced;
   logic [LEVEL_W-1:0]         rsp_floor_level;
   logic [POS_W-1:0]           rsp_voiced_end;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_data = '0;

   // Gate model: registers and session state
   logic [14:0]      min_rms_cfg = GATE_MIN_RMS_RST;
   logic [7:0]       ratio_cfg   = VOICE_GAIN_RST;
   logic [14:0]      cap_cfg     = FLOOR_CAP_RST;
   logic [14:0]      start_cfg   = FLOOR_START_RST;
   logic [3:0]       fall_cfg    = FALL_SHIFT_RST;
   logic [4:0]       rise_cfg    = RISE_SHIFT_RST;
   logic [POS_W-1:0] window_pos  = '0;
   logic [POS_W-1:0] voiced_pos  = '0;
   logic [EST_W-1:0] floor_q31   = {1'b0, FLOOR_START_RST, 16'd0};
   logic [SUM_W-1:0] energy      = '0;
   int unsigned      frame_len   = 0;

   audio_item_type   audio_feed[$];
   frame_result_type frames_due[$];

   int items_queued   = 0;
   int items_taken    = 0;
   int samples_taken  = 0;
   int starts_taken   = 0;
   int frames_checked = 0;
   int mismatch_count = 0;
   int full_cycles    = 0;
   int settings_used  = 1;
   int push_gap       = 0;
   int pop_gap        = 0;
   int drain_hold     = 0;
   int quiet_cycles   = 0;
   bit push_taken     = 1'b0;
   bit push_idling    = 1'b0;
   bit pop_idling     = 1'b0;
   bit hold_request   = 1'b0;

   rms_energy_voice_gate_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_command       (req_command),
      .req_sample        (req_sample),
      .req_samples_after (req_samples_after),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_frame_rms     (rsp_frame_rms),
      .rsp_frame_voiced  (rsp_frame_voiced),
      .rsp_floor_level   (rsp_floor_level),
      .rsp_voiced_end    (rsp_voiced_end),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      if (mismatch_count < MAX_REPORTS)
         $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = 16; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   // Advance the gate by one accepted transaction; queue a frame result when a frame closes.
   function automatic void gate_step(input gate_cmd_type cmd,
                                     input logic signed [SAMPLE_W-1:0] smp,
                                     input logic [AFTER_W-1:0] remaining);
      int               s;
      logic [63:0]      sq;
      logic [63:0]      root;
      logic [63:0]      r_q31;
      logic [63:0]      est;
      logic [63:0]      cap_q31;
      logic [63:0]      thr;
      logic             close;
      logic             voiced;
      frame_result_type res;
      if (cmd == CMD_START) begin
         window_pos = '0;
         voiced_pos = '0;
         floor_q31  = {1'b0, start_cfg, 16'd0};
         energy     = '0;
         frame_len  = 0;
         starts_taken++;
      end else begin
         samples_taken++;
         s = smp;
         sq = 64'(s * s);
         if (window_pos != '1) window_pos++;
         energy = energy + sq[SUM_W-1:0];
         frame_len++;
         close = remaining == 0 || frame_len >= FRAME_MAX_FILL ||
                 (frame_len == FRAME_SAMPLES && remaining >= FRAME_HALF);
         if (close) begin
            root = floor_sqrt(64'(energy) / 64'(frame_len));
            energy = '0;
            frame_len = 0;
            // fast fall, slow rise, then cap
            r_q31 = root << 16;
            est = 64'(floor_q31);
            if (r_q31 < est) est = est - ((est - r_q31) >> fall_cfg);
            else est = est + ((r_q31 - est) >> rise_cfg);
            cap_q31 = 64'(cap_cfg) << 16;
            if (est > cap_q31) est = cap_q31;
            floor_q31 = est[EST_W-1:0];
            thr = 64'(ratio_cfg) * est;
            voiced = (root << 20) >= thr && root >= 64'(min_rms_cfg);
            if (voiced) voiced_pos = window_pos;
            res.rms        = root[RMS_W-1:0];
            res.voiced     = voiced;
            res.level      = est[16 +: LEVEL_W];
            res.voiced_end = voiced_pos;
            frames_due.insert(frames_due.size(), res);
         end
      end
   endfunction

   function automatic void queue_item(input gate_cmd_type cmd, input logic [SAMPLE_W-1:0] smp,
                                      input logic [AFTER_W-1:0] remaining);
      audio_item_type it;
      it.cmd = cmd;
      it.sample = smp;
      it.remaining = remaining;
      audio_feed.insert(audio_feed.size(), it);
      items_queued++;
   endfunction

   function automatic int pick_amp();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return $urandom_range(1, 8);
         2: return $urandom_range(9, 300);
         3: return $urandom_range(300, 3000);
         default: return LOUD;
      endcase
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample(input int amp);
      int v;
      if (amp >= LOUD) v = $urandom_range(0, 65535);
      else v = int'($urandom_range(0, 2 * amp)) - amp;
      return v[SAMPLE_W-1:0];
   endfunction

   // Well-formed chunk: the remaining count runs down to zero.
   function automatic void queue_chunk(input int len, input int amp);
      for (int i = len - 1; i >= 0; i--)
         queue_item(CMD_SAMPLE, pick_sample(amp), AFTER_W'(i));
   endfunction

   function automatic void random_traffic(input int budget);
      int first;
      int sel;
      int len;
      int amp;
      first = items_queued;
      while (items_queued - first < budget) begin
         sel = $urandom_range(0, 99);
         amp = pick_amp();
         if (sel < 72) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
            queue_chunk(len, amp);
         end else if (sel < 84) begin
            // broken chunk: counts that do not add up, end only sometimes flagged
            len = $urandom_range(2, 40);
            for (int i = 0; i < len; i++)
               queue_item(CMD_SAMPLE, pick_sample(amp),
                          (i == len - 1 && $urandom_range(0, 1) == 1) ?
                          AFTER_W'(0) : AFTER_W'($urandom_range(0, 2 * len)));
         end else if (sel < 94) begin
            queue_item(CMD_SAMPLE, pick_sample(LOUD), AFTER_W'($urandom_range(0, 65535)));
         end else begin
            queue_item(CMD_START, pick_sample(LOUD), AFTER_W'($urandom_range(0, 65535)));
         end
      end
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_GATE_MIN_RMS: min_rms_cfg = data[14:0];
         CSR_VOICE_GAIN:   ratio_cfg   = data[7:0];
         CSR_FLOOR_CAP:    cap_cfg     = data[14:0];
         CSR_FLOOR_START:  start_cfg   = data[14:0];
         CSR_FALL_SHIFT:   fall_cfg    = data[3:0];
         CSR_RISE_SHIFT:   rise_cfg    = data[4:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_settings(input int min_rms, input int ratio, input int cap,
                                 input int start_level, input int fall, input int rise);
      write_csr(CSR_GATE_MIN_RMS, CSR_DATA_W'(min_rms));
      write_csr(CSR_VOICE_GAIN, CSR_DATA_W'(ratio));
      write_csr(CSR_FLOOR_CAP, CSR_DATA_W'(cap));
      write_csr(CSR_FLOOR_START, CSR_DATA_W'(start_level));
      write_csr(CSR_FALL_SHIFT, CSR_DATA_W'(fall));
      write_csr(CSR_RISE_SHIFT, CSR_DATA_W'(rise));
      settings_used++;
   endtask

   task automatic write_random_settings();
      write_settings($urandom_range(0, 3000), $urandom_range(0, 255), $urandom_range(0, 32767),
                     $urandom_range(0, 32767), $urandom_range(0, 15), $urandom_range(0, 20));
   endtask

   // Wait for every transaction and result, then let the back end settle.
   task automatic wait_idle();
      while (items_taken != items_queued || frames_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Input side: accept and predict
   always @(posedge clock) begin
      if (!reset && req_push) begin
         if (!req_full) begin
            gate_step(gate_cmd_type'(req_command), req_sample, req_samples_after);
            items_taken++;
            push_taken = 1'b1;
         end else begin
            full_cycles++;
         end
      end
   end

   always @(negedge clock) begin
      audio_item_type next_item;
      if (reset) begin
         req_push <= 1'b0;
      end else if (req_push && !push_taken) begin
         // hold the offered transaction until it is taken
      end else if (push_gap > 0) begin
         push_gap--;
         req_push <= 1'b0;
      end else if (audio_feed.size() != 0) begin
         next_item = audio_feed.pop_front();
         req_command       <= next_item.cmd;
         req_sample        <= next_item.sample;
         req_samples_after <= next_item.remaining;
         req_push          <= 1'b1;
         if (push_idling && $urandom_range(0, 11) == 0) push_gap = $urandom_range(1, 16);
      end else begin
         req_push <= 1'b0;
      end
      push_taken = 1'b0;
   end

   // Result side
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (drain_hold > 0) begin
         drain_hold--;
         rsp_pop <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         drain_hold = HOLD_CYCLES;
         rsp_pop <= 1'b0;
      end else if (pop_gap > 0) begin
         pop_gap--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
         if (pop_idling && $urandom_range(0, 9) == 0) pop_gap = $urandom_range(1, 16);
      end
   end

   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (frames_due.size() == 0) begin
            report_mismatch("unexpected frame result, frame_rms", rsp_frame_rms, 0);
         end else begin
            want = frames_due.pop_front();
            frames_checked++;
            if (rsp_frame_rms !== want.rms)
               report_mismatch("frame_rms", rsp_frame_rms, want.rms);
            if (rsp_frame_voiced !== want.voiced)
               report_mismatch("frame_voiced", rsp_frame_voiced, want.voiced);
            if (rsp_floor_level !== want.level)
               report_mismatch("floor_level", rsp_floor_level, want.level);
            if (rsp_voiced_end !== want.voiced_end)
               report_mismatch("voiced_end", rsp_voiced_end, want.voiced_end);
         end
      end
   end

   // Watchdog: count cycles with work pending and no transaction on any port
   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || (csr_valid && csr_ready) ||
             !(audio_feed.size() != 0 || req_push || frames_due.size() != 0 || csr_valid))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t ns: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      push_idling = 1'b1;
      pop_idling  = 1'b1;

      // Reset defaults: field extremes, one-sample frames, start commands
      queue_item(CMD_SAMPLE, 16'h7FFF, 16'd0);
      queue_item(CMD_SAMPLE, 16'h8000, 16'd0);
      queue_item(CMD_SAMPLE, 16'h0000, 16'd0);
      queue_item(CMD_SAMPLE, 16'h0001, 16'hFFFF);
      queue_item(CMD_SAMPLE, 16'hFFFF, 16'h8000);
      queue_item(CMD_SAMPLE, 16'h8000, 16'h7FFF);
      queue_item(CMD_SAMPLE, 16'h7FFF, 16'd0);
      queue_item(CMD_START, 16'hFFFF, 16'hFFFF);
      queue_item(CMD_SAMPLE, 16'd20000, 16'd2);
      queue_item(CMD_SAMPLE, -16'sd20000, 16'd1);
      queue_item(CMD_SAMPLE, 16'd30000, 16'd0);
      queue_item(CMD_SAMPLE, 16'd5, 16'd1);
      queue_item(CMD_SAMPLE, -16'sd5, 16'd0);
      queue_item(CMD_SAMPLE, 16'd100, 16'd0);
      queue_item(CMD_SAMPLE, -16'sd100, 16'd0);
      queue_item(CMD_START, 16'h0000, 16'h0000);
      queue_item(CMD_SAMPLE, 16'd0, 16'd0);
      random_traffic(250);
      wait_idle();

      // Low extremes, with floor cap and start level at their maximum
      write_settings(0, 0, 32767, 32767, 0, 0);
      queue_item(CMD_START, pick_sample(LOUD), AFTER_W'($urandom_range(0, 65535)));
      random_traffic(250);
      wait_idle();

      // High extremes, with floor cap and start level at zero, rise shift past its range
      write_settings(32767, 255, 0, 0, 15, 31);
      queue_item(CMD_START, pick_sample(LOUD), AFTER_W'($urandom_range(0, 65535)));
      random_traffic(250);
      wait_idle();

      // Stall the result side long enough to back up the queues
      write_random_settings();
      queue_item(CMD_START, pick_sample(LOUD), AFTER_W'($urandom_range(0, 65535)));
      for (int n = 0; n < 90; n++) queue_chunk($urandom_range(1, 2), pick_amp());
      @(posedge clock);
      hold_request = 1'b1;
      random_traffic(200);
      wait_idle();

      // New settings without a start: floor carries over
      write_random_settings();
      pop_idling = 1'b0;
      random_traffic(250);
      wait_idle();

      // Back to defaults, no idling on either side
      write_settings(GATE_MIN_RMS_RST, VOICE_GAIN_RST, FLOOR_CAP_RST, FLOOR_START_RST,
                     FALL_SHIFT_RST, RISE_SHIFT_RST);
      push_idling = 1'b0;
      queue_item(CMD_START, pick_sample(LOUD), AFTER_W'($urandom_range(0, 65535)));
      random_traffic(250);
      wait_idle();

      $display("Run covered %0d audio samples and %0d start commands, %0d frames checked.",
               samples_taken, starts_taken, frames_checked);
      $display("Register settings used: %0d; cycles with input held off by full: %0d.",
               settings_used, full_cycles);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
